/* hw/rtl/twdws_pkg.sv */
package twdws_pkg;

    // Part of a frame being sent
    typedef enum logic [1:0] {
        STAGE_START = 2'd0,
        STAGE_BITS  = 2'd1,
        STAGE_TAIL  = 2'd2
    } stage_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_DATA_CMD  = 2'd0;
    localparam logic [1:0] CFG_ADDR_CMD  = 2'd1;
    localparam logic [1:0] CFG_TRAIL     = 2'd2;
    localparam logic [1:0] CFG_DISP_CMD  = 2'd3;

    // Configuration reset values
    localparam logic [7:0] DATA_CMD_RST  = 8'h40;
    localparam logic [7:0] ADDR_CMD_RST  = 8'hC0;
    localparam logic [7:0] TRAIL_RST     = 8'h00;
    localparam logic [7:0] DISP_CMD_RST  = 8'h88;

    // Frame numbering and counter limits
    localparam logic [1:0] FRAME_FIRST   = 2'd0;
    localparam logic [1:0] FRAME_ADDR    = 2'd1;
    localparam logic [1:0] FRAME_LAST    = 2'd2;
    localparam logic [1:0] ADDR_FRAME_LEN = 2'd3;
    localparam logic [1:0] OTHER_FRAME_LEN = 2'd1;
    localparam logic [2:0] BIT_LAST      = 3'd7;
    localparam logic [2:0] TAIL_LAST     = 3'd5;

    // Line state bit positions
    localparam int CLK_POS = 0;
    localparam int DIO_POS = 1;

    // Byte number b of frame f
    function automatic logic [7:0] frame_byte(
        input logic [1:0] f,
        input logic [1:0] b,
        input logic [7:0] data_cmd,
        input logic [7:0] addr_cmd,
        input logic [7:0] held,
        input logic [7:0] trail,
        input logic [7:0] disp_cmd
    );
        logic [7:0] r;
        if (f == FRAME_FIRST)
        begin
            r = data_cmd;
        end
        else if (f == FRAME_ADDR)
        begin
            if (b == 2'd0)
            begin
                r = addr_cmd;
            end
            else if (b == 2'd1)
            begin
                r = held;
            end
            else
            begin
                r = trail;
            end
        end
        else
        begin
            r = disp_cmd;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/two_wire_display_write_sequencer.sv */
// Open-drain two-wire display write sequencer. A start request (func = 1) latches the display
// byte and opens a three-frame transfer; it is ignored while a transfer is running. Each tick
// request (func = 0) then moves the clock and data lines by one waveform step: a start tick,
// three ticks per bit LSB first, and a six-tick acknowledge-and-stop tail per frame, 141 ticks
// in all. done_res marks the last tick. Every request gives one result in the cycle after it is
// accepted; the block takes one request per clock while the result is not stalled, set by a
// single register stage holding the sequencer counters and the result register, which a
// stalled output holds while a new request is still accepted once the result is taken in the
// same cycle. Configuration bytes are read when each byte is loaded for shifting.
module two_wire_display_write_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    // configuration write port
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wdata,
    // request channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       func,
    input  logic [7:0] value,
    // result channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic       clk_low,
    output logic       dio_low,
    output logic       busy_res,
    output logic       done_res
);

    // configuration registers
    logic [7:0] data_cmd_reg;
    logic [7:0] addr_cmd_reg;
    logic [7:0] trail_reg;
    logic [7:0] disp_cmd_reg;

    // sequencer state
    logic [1:0]          frame_reg,  frame_next;
    logic [1:0]          byte_reg,   byte_next;
    logic [2:0]          bit_reg,    bit_next;
    logic [2:0]          phase_reg,  phase_next;
    logic [7:0]          shift_reg,  shift_next;
    logic [7:0]          held_reg,   held_next;
    logic                active_reg, active_next;
    logic [1:0]          line_reg,   line_next;
    twdws_pkg::stage_t   stage_reg,  stage_next;

    // result register
    logic out_valid_reg, out_valid_next;
    logic clk_low_reg,   clk_low_next;
    logic dio_low_reg,   dio_low_next;
    logic busy_reg,      busy_next;
    logic done_reg,      done_next;

    logic accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_cmd_reg <= twdws_pkg::DATA_CMD_RST;
            addr_cmd_reg <= twdws_pkg::ADDR_CMD_RST;
            trail_reg    <= twdws_pkg::TRAIL_RST;
            disp_cmd_reg <= twdws_pkg::DISP_CMD_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                twdws_pkg::CFG_DATA_CMD: data_cmd_reg <= cfg_wdata;
                twdws_pkg::CFG_ADDR_CMD: addr_cmd_reg <= cfg_wdata;
                twdws_pkg::CFG_TRAIL:    trail_reg    <= cfg_wdata;
                twdws_pkg::CFG_DISP_CMD: disp_cmd_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // next state and result for one request
    always_comb
    begin
        logic [1:0] frame_len;
        frame_next     = frame_reg;
        byte_next      = byte_reg;
        bit_next       = bit_reg;
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        held_next      = held_reg;
        active_next    = active_reg;
        line_next      = line_reg;
        stage_next     = stage_reg;
        busy_next      = busy_reg;
        done_next      = done_reg;
        clk_low_next   = clk_low_reg;
        dio_low_next   = dio_low_reg;
        out_valid_next = out_valid_reg && !out_ready;
        frame_len      = (frame_reg == twdws_pkg::FRAME_ADDR) ?
                         twdws_pkg::ADDR_FRAME_LEN : twdws_pkg::OTHER_FRAME_LEN;

        if (accept)
        begin
            busy_next = active_reg;
            done_next = 1'b0;
            if (func)
            begin
                busy_next = 1'b1;
                if (!active_reg)
                begin
                    held_next   = value;
                    active_next = 1'b1;
                    frame_next  = twdws_pkg::FRAME_FIRST;
                    byte_next   = 2'd0;
                    bit_next    = 3'd0;
                    phase_next  = 3'd0;
                    stage_next  = twdws_pkg::STAGE_START;
                end
            end
            else if (active_reg)
            begin
                case (stage_reg)
                    twdws_pkg::STAGE_START:
                    begin
                        line_next[twdws_pkg::DIO_POS] = 1'b1;
                        stage_next = twdws_pkg::STAGE_BITS;
                        byte_next  = 2'd0;
                        bit_next   = 3'd0;
                        phase_next = 3'd0;
                        shift_next = twdws_pkg::frame_byte(frame_reg, 2'd0, data_cmd_reg,
                            addr_cmd_reg, held_reg, trail_reg, disp_cmd_reg);
                    end
                    twdws_pkg::STAGE_BITS:
                    begin
                        if (phase_reg == 3'd0)
                        begin
                            line_next[twdws_pkg::CLK_POS] = 1'b1;
                            phase_next = 3'd1;
                        end
                        else if (phase_reg == 3'd1)
                        begin
                            line_next[twdws_pkg::DIO_POS] = !shift_reg[0];
                            phase_next = 3'd2;
                        end
                        else
                        begin
                            line_next[twdws_pkg::CLK_POS] = 1'b0;
                            phase_next = 3'd0;
                            shift_next = {1'b0, shift_reg[7:1]};
                            bit_next   = bit_reg + 3'd1;
                            if (bit_reg == twdws_pkg::BIT_LAST)
                            begin
                                byte_next = byte_reg + 2'd1;
                                if (byte_next >= frame_len)
                                begin
                                    stage_next = twdws_pkg::STAGE_TAIL;
                                end
                                else
                                begin
                                    shift_next = twdws_pkg::frame_byte(frame_reg, byte_next,
                                        data_cmd_reg, addr_cmd_reg, held_reg, trail_reg,
                                        disp_cmd_reg);
                                end
                            end
                        end
                    end
                    default:
                    begin
                        // acknowledge and stop tail
                        case (phase_reg)
                            3'd0:
                            begin
                                line_next[twdws_pkg::CLK_POS] = 1'b1;
                                line_next[twdws_pkg::DIO_POS] = 1'b0;
                            end
                            3'd1: line_next[twdws_pkg::CLK_POS] = 1'b0;
                            3'd2: line_next[twdws_pkg::CLK_POS] = 1'b1;
                            3'd3: line_next[twdws_pkg::DIO_POS] = 1'b1;
                            3'd4: line_next[twdws_pkg::CLK_POS] = 1'b0;
                            default: line_next[twdws_pkg::DIO_POS] = 1'b0;
                        endcase
                        if (phase_reg >= twdws_pkg::TAIL_LAST)
                        begin
                            phase_next = 3'd0;
                            stage_next = twdws_pkg::STAGE_START;
                            if (frame_reg >= twdws_pkg::FRAME_LAST)
                            begin
                                done_next   = 1'b1;
                                active_next = 1'b0;
                                frame_next  = twdws_pkg::FRAME_FIRST;
                                byte_next   = 2'd0;
                                bit_next    = 3'd0;
                            end
                            else
                            begin
                                frame_next = frame_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            phase_next = phase_reg + 3'd1;
                        end
                    end
                endcase
            end
            clk_low_next   = line_next[twdws_pkg::CLK_POS];
            dio_low_next   = line_next[twdws_pkg::DIO_POS];
            out_valid_next = 1'b1;
        end
    end

    // sequencer control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg     <= twdws_pkg::FRAME_FIRST;
            byte_reg      <= 2'd0;
            bit_reg       <= 3'd0;
            phase_reg     <= 3'd0;
            active_reg    <= 1'b0;
            line_reg      <= 2'd0;
            stage_reg     <= twdws_pkg::STAGE_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            frame_reg     <= frame_next;
            byte_reg      <= byte_next;
            bit_reg       <= bit_next;
            phase_reg     <= phase_next;
            active_reg    <= active_next;
            line_reg      <= line_next;
            stage_reg     <= stage_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        held_reg    <= held_next;
        clk_low_reg <= clk_low_next;
        dio_low_reg <= dio_low_next;
        busy_reg    <= busy_next;
        done_reg    <= done_next;
    end

    assign out_valid = out_valid_reg;
    assign clk_low   = clk_low_reg;
    assign dio_low   = dio_low_reg;
    assign busy_res  = busy_reg;
    assign done_res  = done_reg;

endmodule
